/* sv/i2ccsp_pkg.sv */
// ----------------------------------------------------------------------------
// i2ccsp_pkg
// shared types and constants of the i2c command stream packer
// ----------------------------------------------------------------------------
package i2ccsp_pkg;

  localparam int LenW = 12;   // msg_length field
  localparam int OffW = 12;   // byte_offset field
  localparam int PosW = 13;   // write position and total length

  localparam int unsigned ReadChunk = 32;

  localparam logic [7:0] CmdStream = 8'hAA;
  localparam logic [7:0] CmdEnd    = 8'h00;
  localparam logic [7:0] CmdStart  = 8'h74;
  localparam logic [7:0] CmdStop   = 8'h75;
  localparam logic [7:0] CmdOut    = 8'h80;
  localparam logic [7:0] CmdIn     = 8'hC0;

  localparam logic [1:0] StatOk         = 2'd0;
  localparam logic [1:0] StatOverflow   = 2'd1;
  localparam logic [1:0] StatTooLong    = 2'd2;
  localparam logic [1:0] StatUnexpected = 2'd3;

  typedef enum logic [1:0] {
    OP_WR_HDR  = 2'd0,
    OP_WR_DATA = 2'd1,
    OP_READ    = 2'd2,
    OP_FINISH  = 2'd3
  } op_e;

  // which command byte the datapath places in the result
  typedef enum logic [3:0] {
    SEL_STREAM,
    SEL_END,
    SEL_START,
    SEL_STOP,
    SEL_OUT_FIRST,
    SEL_OUT_NEXT,
    SEL_OUT_ONE,
    SEL_ADDR_WR,
    SEL_ADDR_RD,
    SEL_DATA,
    SEL_IN_FULL,
    SEL_IN_PART,
    SEL_IN_BARE
  } byte_sel_e;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       emit;
    logic       has;
    byte_sel_e  sel;
    logic [1:0] stat;
    logic       last;
    logic       fin_total;
    logic       close_seg;
    logic       msg_clear;
    logic       hdr_load;
    logic       chunk_load;
    logic       dat_dec;
    logic       rd_next;
    logic       set_started;
    logic       set_ovf;
    logic       clear_all;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic ovf;
    logic len_zero;
    logic len_too_long;
    logic msg_zero;
    logic chunk_zero;
    logic pos_zero;
    logic pos_late;
    logic pos_final;
    logic close_ovf;
    logic rem_gt_chunk;
    logic rem_gt1;
    logic started;
    logic out_ready;
  } dp_sts_t;

endpackage

/* sv/i2c_command_stream_packer_unit.sv */
// ----------------------------------------------------------------------------
// i2c_command_stream_packer_unit
// packs i2c write/read messages into segmented adapter command bytes
// ----------------------------------------------------------------------------
// Takes one item at a time (write header, write data byte, read message or
// finish) and turns it into command bytes, each returned with its buffer
// offset, for a command buffer cut into SEGMENT_BYTES-byte segments that
// open with STREAM and close with END. An item is taken in, goes through
// dispatch and then through the sequencer, which gives out its result
// bytes; a read passes through a top state again for each 32-byte IN
// chunk. The pace is set by the sequencer issuing one result per cycle
// into a single output register; a stalled output holds the sequencer.
// Items that give no result (a zero-length header or read, anything after
// an overflow but finish) go back to idle straight from dispatch. A
// finish item's closing END carries the total buffer length.
module i2c_command_stream_packer_unit #(
  parameter int SEGMENT_BYTES  = 32,
  parameter int SEGMENT_LIMIT  = 128,
  parameter int READ_LEN_LIMIT = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  op_i,
  input  logic [6:0]                  dev_addr_i,
  input  logic [i2ccsp_pkg::LenW-1:0] msg_length_i,
  input  logic [7:0]                  data_byte_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        has_byte_o,
  output logic [7:0]                  cmd_byte_o,
  output logic [i2ccsp_pkg::OffW-1:0] byte_offset_o,
  output logic [i2ccsp_pkg::PosW-1:0] total_length_o,
  output logic [1:0]                  status_o,
  output logic                        last_o
);
  import i2ccsp_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencer: decides which byte goes out next and which state updates
  i2ccsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: position, segment and message counters plus output register
  i2ccsp_datapath #(
    .SEGMENT_BYTES  (SEGMENT_BYTES),
    .SEGMENT_LIMIT  (SEGMENT_LIMIT),
    .READ_LEN_LIMIT (READ_LEN_LIMIT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op_i),
    .dev_addr_i     (dev_addr_i),
    .msg_length_i   (msg_length_i),
    .data_byte_i    (data_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .has_byte_o     (has_byte_o),
    .cmd_byte_o     (cmd_byte_o),
    .byte_offset_o  (byte_offset_o),
    .total_length_o (total_length_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule

/* sv/i2ccsp_ctrl.sv */
// ----------------------------------------------------------------------------
// i2ccsp_ctrl
// sequencer that walks each item through its command bytes, one per cycle unless the output stalls
// ----------------------------------------------------------------------------
module i2ccsp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  i2ccsp_pkg::dp_sts_t  sts_i,
  output i2ccsp_pkg::ctl_cmd_t cmd_o
);
  import i2ccsp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CLOSE,
    ST_STREAM,
    ST_HDR_START,
    ST_HDR_OUT,
    ST_HDR_ADDR,
    ST_DAT_OUT,
    ST_DAT_BYTE,
    ST_RD_TOP,
    ST_RD_START,
    ST_RD_OUT,
    ST_RD_ADDR,
    ST_RD_IN,
    ST_RD_LAST,
    ST_FIN_STOP,
    ST_FIN_END,
    ST_OVF,
    ST_TOO_LONG,
    ST_UNEXP
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sel  = SEL_END;
    cmd_o.stat = StatOk;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.op == OP_FINISH) begin
          if (sts_i.ovf) state_d = ST_OVF;
          else if (sts_i.pos_final) state_d = ST_CLOSE;
          else state_d = ST_FIN_STOP;
        end else if (sts_i.ovf) begin
          state_d = ST_IDLE;
        end else if (sts_i.op == OP_WR_HDR) begin
          cmd_o.msg_clear = 1'b1;
          if (sts_i.len_zero) state_d = ST_IDLE;
          else if (sts_i.pos_zero) state_d = ST_STREAM;
          else state_d = ST_CLOSE;
        end else if (sts_i.op == OP_WR_DATA) begin
          if (sts_i.msg_zero) state_d = ST_UNEXP;
          else if (!sts_i.chunk_zero) state_d = ST_DAT_BYTE;
          else if (sts_i.pos_zero) state_d = ST_STREAM;
          else state_d = ST_CLOSE;
        end else begin
          if (sts_i.len_too_long) begin
            state_d = ST_TOO_LONG;
          end else begin
            cmd_o.msg_clear = 1'b1;
            state_d = sts_i.len_zero ? ST_IDLE : ST_RD_TOP;
          end
        end
      end
      ST_CLOSE: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.has = 1'b1;
          cmd_o.sel = SEL_END;
          cmd_o.close_seg = 1'b1;
          state_d = sts_i.close_ovf ? ST_OVF : ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.has = 1'b1;
          cmd_o.sel = SEL_STREAM;
          case (sts_i.op)
            OP_WR_HDR:  state_d = ST_HDR_START;
            OP_WR_DATA: state_d = ST_DAT_OUT;
            OP_READ:    state_d = sts_i.started ? ST_RD_IN : ST_RD_START;
            default:    state_d = ST_FIN_STOP;
          endcase
        end
      end
      ST_HDR_START: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.has = 1'b1;
          cmd_o.sel = SEL_START;
          state_d = ST_HDR_OUT;
        end
      end
      ST_HDR_OUT: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.has = 1'b1;
          cmd_o.sel = SEL_OUT_FIRST;
          state_d = ST_HDR_ADDR;
        end
      end
      ST_HDR_ADDR: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.has = 1'b1;
          cmd_o.sel = SEL_ADDR_WR;
          cmd_o.last = 1'b1;
          cmd_o.hdr_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DAT_OUT: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.has = 1'b1;
          cmd_o.sel = SEL_OUT_NEXT;
          cmd_o.chunk_load = 1'b1;
          state_d = ST_DAT_BYTE;
        end
      end
      ST_DAT_BYTE: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.has = 1'b1;
          cmd_o.sel = SEL_DATA;
          cmd_o.last = 1'b1;
          cmd_o.dat_dec = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RD_TOP: begin
        if (sts_i.pos_zero) state_d = ST_STREAM;
        else if (sts_i.started || sts_i.pos_late) state_d = ST_CLOSE;
        else state_d = ST_RD_START;
      end
      ST_RD_START: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.has = 1'b1;
          cmd_o.sel = SEL_START;
          state_d = ST_RD_OUT;
        end
      end
      ST_RD_OUT: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.has = 1'b1;
          cmd_o.sel = SEL_OUT_ONE;
          state_d = ST_RD_ADDR;
        end
      end
      ST_RD_ADDR: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.has = 1'b1;
          cmd_o.sel = SEL_ADDR_RD;
          cmd_o.set_started = 1'b1;
          state_d = ST_RD_IN;
        end
      end
      ST_RD_IN: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.has = 1'b1;
          if (sts_i.rem_gt_chunk) begin
            cmd_o.sel = SEL_IN_FULL;
            cmd_o.rd_next = 1'b1;
            state_d = ST_RD_TOP;
          end else if (sts_i.rem_gt1) begin
            cmd_o.sel = SEL_IN_PART;
            state_d = ST_RD_LAST;
          end else begin
            cmd_o.sel = SEL_IN_BARE;
            cmd_o.last = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_RD_LAST: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.has = 1'b1;
          cmd_o.sel = SEL_IN_BARE;
          cmd_o.last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FIN_STOP: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.has = 1'b1;
          cmd_o.sel = SEL_STOP;
          state_d = ST_FIN_END;
        end
      end
      ST_FIN_END: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.has = 1'b1;
          cmd_o.sel = SEL_END;
          cmd_o.last = 1'b1;
          cmd_o.fin_total = 1'b1;
          cmd_o.clear_all = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_OVF: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.stat = StatOverflow;
          cmd_o.last = 1'b1;
          // finish drops the whole transaction, other items latch the error
          if (sts_i.op == OP_FINISH) cmd_o.clear_all = 1'b1;
          else cmd_o.set_ovf = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_TOO_LONG: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.stat = StatTooLong;
          cmd_o.last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_UNEXP: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.stat = StatUnexpected;
          cmd_o.last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/i2ccsp_datapath.sv */
// ----------------------------------------------------------------------------
// i2ccsp_datapath
// item registers, buffer position tracking and the output register
// ----------------------------------------------------------------------------
module i2ccsp_datapath #(
  parameter int SEGMENT_BYTES  = 32,
  parameter int SEGMENT_LIMIT  = 128,
  parameter int READ_LEN_LIMIT = 512
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [1:0]                         op_i,
  input  logic [6:0]                         dev_addr_i,
  input  logic [i2ccsp_pkg::LenW-1:0]        msg_length_i,
  input  logic [7:0]                         data_byte_i,
  input  i2ccsp_pkg::ctl_cmd_t               cmd_i,
  output i2ccsp_pkg::dp_sts_t                sts_o,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic                               has_byte_o,
  output logic [7:0]                         cmd_byte_o,
  output logic [i2ccsp_pkg::OffW-1:0]        byte_offset_o,
  output logic [i2ccsp_pkg::PosW-1:0]        total_length_o,
  output logic [1:0]                         status_o,
  output logic                               last_o
);
  import i2ccsp_pkg::*;

  localparam int SegPosW = $clog2(SEGMENT_BYTES + 1);
  localparam int SegIdxW = $clog2(SEGMENT_LIMIT + 1);
  localparam int ChunkW  = $clog2(SEGMENT_BYTES - 2);

  // captured item
  op_e             op_q;
  logic [6:0]      addr_q;
  logic [LenW-1:0] len_q, len_d;   // read length doubles as bytes still to request
  logic [7:0]      data_q;

  // packing state
  logic [PosW-1:0]    wp_q, wp_d;
  logic [PosW-1:0]    base_q, base_d;
  logic [SegPosW-1:0] pos_q, pos_d;
  logic [SegIdxW-1:0] idx_q, idx_d, idx_nxt;
  logic [LenW-1:0]    msg_q, msg_d;
  logic [ChunkW-1:0]  chunk_q, chunk_d;
  logic               ovf_q, ovf_d;
  logic               started_q, started_d;

  // output register
  logic            out_valid_q, out_valid_d;
  logic            has_q;
  logic [7:0]      byte_q;
  logic [OffW-1:0] off_q;
  logic [PosW-1:0] total_q;
  logic [1:0]      stat_q;
  logic            last_q;

  logic              out_ready;
  logic              close_ovf;
  logic [ChunkW-1:0] tw_first, tw_next;
  logic [7:0]        sel_byte;

  assign idx_nxt   = idx_q + SegIdxW'(1);
  assign close_ovf = (idx_nxt >= SegIdxW'(SEGMENT_LIMIT));
  assign out_ready = !out_valid_q || !out_stall_i;

  assign tw_first = (len_q < LenW'(SEGMENT_BYTES - 5)) ? ChunkW'(len_q)
                                                       : ChunkW'(SEGMENT_BYTES - 5);
  assign tw_next  = (msg_q < LenW'(SEGMENT_BYTES - 3)) ? ChunkW'(msg_q)
                                                       : ChunkW'(SEGMENT_BYTES - 3);

  always_comb begin
    case (cmd_i.sel)
      SEL_STREAM:    sel_byte = CmdStream;
      SEL_END:       sel_byte = CmdEnd;
      SEL_START:     sel_byte = CmdStart;
      SEL_STOP:      sel_byte = CmdStop;
      SEL_OUT_FIRST: sel_byte = CmdOut | (8'(tw_first) + 8'd1);
      SEL_OUT_NEXT:  sel_byte = CmdOut | 8'(tw_next);
      SEL_OUT_ONE:   sel_byte = CmdOut | 8'd1;
      SEL_ADDR_WR:   sel_byte = {addr_q, 1'b0};
      SEL_ADDR_RD:   sel_byte = {addr_q, 1'b1};
      SEL_DATA:      sel_byte = data_q;
      SEL_IN_FULL:   sel_byte = CmdIn | 8'(ReadChunk);
      SEL_IN_PART:   sel_byte = CmdIn | 8'(len_q - LenW'(1));
      SEL_IN_BARE:   sel_byte = CmdIn;
      default:       sel_byte = CmdEnd;
    endcase
  end

  always_comb begin
    sts_o.op           = op_q;
    sts_o.ovf          = ovf_q;
    sts_o.len_zero     = (len_q == '0);
    sts_o.len_too_long = (len_q > LenW'(READ_LEN_LIMIT));
    sts_o.msg_zero     = (msg_q == '0);
    sts_o.chunk_zero   = (chunk_q == '0);
    sts_o.pos_zero     = (pos_q == '0);
    sts_o.pos_late     = (pos_q >= SegPosW'(SEGMENT_BYTES - 7));
    sts_o.pos_final    = (pos_q == SegPosW'(SEGMENT_BYTES - 1));
    sts_o.close_ovf    = close_ovf;
    sts_o.rem_gt_chunk = (len_q > LenW'(ReadChunk));
    sts_o.rem_gt1      = (len_q > LenW'(1));
    sts_o.started      = started_q;
    sts_o.out_ready    = out_ready;
  end

  always_comb begin
    wp_d      = wp_q;
    base_d    = base_q;
    pos_d     = pos_q;
    idx_d     = idx_q;
    msg_d     = msg_q;
    chunk_d   = chunk_q;
    ovf_d     = ovf_q;
    started_d = started_q;
    len_d     = len_q;
    if (cmd_i.capture) begin
      started_d = 1'b0;
      len_d     = msg_length_i;
    end
    if (cmd_i.rd_next) len_d = len_q - LenW'(ReadChunk);
    if (cmd_i.emit && cmd_i.has) begin
      wp_d  = wp_q + PosW'(1);
      pos_d = pos_q + SegPosW'(1);
    end
    if (cmd_i.close_seg) begin
      idx_d = idx_nxt;
      if (!close_ovf) begin
        base_d = base_q + PosW'(SEGMENT_BYTES);
        wp_d   = base_d;
        pos_d  = '0;
      end
    end
    if (cmd_i.msg_clear) begin
      msg_d   = '0;
      chunk_d = '0;
    end
    if (cmd_i.hdr_load) begin
      msg_d   = len_q;
      chunk_d = tw_first;
    end
    if (cmd_i.chunk_load) chunk_d = tw_next;
    if (cmd_i.dat_dec) begin
      msg_d   = msg_q - LenW'(1);
      chunk_d = chunk_q - ChunkW'(1);
    end
    if (cmd_i.set_started) started_d = 1'b1;
    if (cmd_i.set_ovf) ovf_d = 1'b1;
    if (cmd_i.clear_all) begin
      wp_d    = '0;
      base_d  = '0;
      pos_d   = '0;
      idx_d   = '0;
      msg_d   = '0;
      chunk_d = '0;
      ovf_d   = 1'b0;
    end
  end

  assign out_valid_d = cmd_i.emit ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      base_q      <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      msg_q       <= '0;
      chunk_q     <= '0;
      ovf_q       <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      base_q      <= base_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      msg_q       <= msg_d;
      chunk_q     <= chunk_d;
      ovf_q       <= ovf_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    if (cmd_i.capture) begin
      op_q   <= op_e'(op_i);
      addr_q <= dev_addr_i;
      data_q <= data_byte_i;
    end
    if (cmd_i.emit) begin
      has_q   <= cmd_i.has;
      byte_q  <= cmd_i.has ? sel_byte : 8'd0;
      off_q   <= cmd_i.has ? wp_q[OffW-1:0] : '0;
      total_q <= cmd_i.fin_total ? (wp_q + PosW'(1)) : '0;
      stat_q  <= cmd_i.stat;
      last_q  <= cmd_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign has_byte_o     = has_q;
  assign cmd_byte_o     = byte_q;
  assign byte_offset_o  = off_q;
  assign total_length_o = total_q;
  assign status_o       = stat_q;
  assign last_o         = last_q;

endmodule

/* sv/i2ccsp_checker.sv */
// ----------------------------------------------------------------------------
// i2ccsp_checker
// port-level checks of the command stream packer, bound to the top level
// ----------------------------------------------------------------------------
module i2ccsp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [1:0]                  op_i,
  input logic [6:0]                  dev_addr_i,
  input logic [i2ccsp_pkg::LenW-1:0] msg_length_i,
  input logic [7:0]                  data_byte_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        has_byte_o,
  input logic [7:0]                  cmd_byte_o,
  input logic [i2ccsp_pkg::OffW-1:0] byte_offset_o,
  input logic [i2ccsp_pkg::PosW-1:0] total_length_o,
  input logic [1:0]                  status_o,
  input logic                        last_o
);
  import i2ccsp_pkg::*;

  // a stalled item holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(op_i) && $stable(dev_addr_i)
      && $stable(msg_length_i) && $stable(data_byte_i))
    else $error("stalled item changed");

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cmd_byte_o)
      && $stable(byte_offset_o) && $stable(status_o) && $stable(last_o))
    else $error("stalled result changed");

  // the block works on one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken while previous item in progress");

  // status results carry no byte, and an error is always the item's last result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatOk |-> !has_byte_o && last_o
      && cmd_byte_o == 8'd0 && byte_offset_o == '0)
    else $error("malformed status result");

  // total length only on the closing END of a finish
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && total_length_o != '0 |-> last_o && has_byte_o
      && cmd_byte_o == CmdEnd && status_o == StatOk)
    else $error("total length outside finish end");

endmodule

bind i2c_command_stream_packer_unit i2ccsp_checker u_i2ccsp_checker (.*);

/* test/i2c_command_stream_packer_unit_tb.sv */
// ----------------------------------------------------------------------------
// i2c_command_stream_packer_unit_tb
// self-checking bench for the i2c command stream packer
// ----------------------------------------------------------------------------
// A directed table comes first: empty finish, stray data bytes, reads that are
// too long, zero-length headers, short and long writes and reads, and a run of
// full-size reads that overflows the segment space. Random transactions
// follow in four idling phases. Each accepted item goes through a local
// model of the packer, and every result that comes back is compared field by
// field with the oldest command byte still awaited.
module i2c_command_stream_packer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2ccsp_pkg::*;

  localparam int SegBytes     = 32;
  localparam int SegLimit     = 128;
  localparam int ReadLenLimit = 512;

  localparam int PhaseItems  = 50;    // random items per idling phase
  localparam int QuietLimit  = 2000;  // cycles with no handshake at all
  localparam int TailCycles  = 30;    // quiet wait once all results are in
  localparam int MaxReports  = 30;

  // one result of the packer
  typedef struct packed {
    logic            has_byte;
    logic [7:0]      cmd_byte;
    logic [OffW-1:0] byte_offset;
    logic [PosW-1:0] total_length;
    logic [1:0]      status;
    logic            last;
  } cmd_res_t;

  // one stimulus row; typed rows carry their results written out by hand
  typedef struct packed {
    op_e             op;
    logic [6:0]      addr;
    logic [LenW-1:0] len;
    logic [7:0]      data;
    logic            typed;
    logic [1:0]      n_typed;
    cmd_res_t        r0;
    cmd_res_t        r1;
  } stim_row_t;

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            in_valid_i   = 1'b0;
  logic            in_stall_o;
  logic [1:0]      op_i         = OP_WR_HDR;
  logic [6:0]      dev_addr_i   = '0;
  logic [LenW-1:0] msg_length_i = '0;
  logic [7:0]      data_byte_i  = '0;
  logic            out_valid_o;
  logic            out_stall_i  = 1'b0;
  logic            has_byte_o;
  logic [7:0]      cmd_byte_o;
  logic [OffW-1:0] byte_offset_o;
  logic [PosW-1:0] total_length_o;
  logic [1:0]      status_o;
  logic            last_o;

  i2c_command_stream_packer_unit #(
    .SEGMENT_BYTES (SegBytes),
    .SEGMENT_LIMIT (SegLimit),
    .READ_LEN_LIMIT(ReadLenLimit)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .dev_addr_i    (dev_addr_i),
    .msg_length_i  (msg_length_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .has_byte_o    (has_byte_o),
    .cmd_byte_o    (cmd_byte_o),
    .byte_offset_o (byte_offset_o),
    .total_length_o(total_length_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  // 4 ns clock
  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // packer model: buffer position, segment, pending write bytes
  // --------------------------------------------------------------------------
  logic [PosW-1:0] pk_pos        = '0;
  logic [7:0]      pk_seg        = '0;
  logic [LenW-1:0] pk_msg_left   = '0;
  logic [4:0]      pk_chunk_left = '0;
  bit              pk_ovf        = 1'b0;

  cmd_res_t item_cmds[$];      // results of the item being modeled
  cmd_res_t expected_cmds[$];  // results awaited from the block, oldest first

  int       mismatches  = 0;
  int       items_sent  = 0;
  int       quiet_cycles = 0;
  int       gap_pct     = 0;
  int       stall_pct   = 0;
  cmd_res_t next_cmd;

  function automatic void put_res(bit has, logic [7:0] b, logic [PosW-1:0] off,
                                  logic [1:0] st);
    cmd_res_t r;
    r = '0;
    r.has_byte    = has;
    r.cmd_byte    = b;
    r.byte_offset = off[OffW-1:0];
    r.status      = st;
    item_cmds.push_back(r);
  endfunction

  function automatic void emit_cmd(logic [7:0] b);
    put_res(1'b1, b, pk_pos, StatOk);
    pk_pos++;
  endfunction

  function automatic void clear_packer();
    pk_pos        = '0;
    pk_seg        = '0;
    pk_msg_left   = '0;
    pk_chunk_left = '0;
    pk_ovf        = 1'b0;
  endfunction

  function automatic int unsigned seg_offset();
    return int'(pk_pos) % SegBytes;
  endfunction

  // END, then on to the next segment; 0 when the segment space runs out
  function automatic bit close_seg();
    emit_cmd(CmdEnd);
    pk_seg++;
    if (pk_seg >= SegLimit) begin
      pk_ovf = 1'b1;
      put_res(1'b0, 8'h00, '0, StatOverflow);
      return 1'b0;
    end
    pk_pos = PosW'(int'(pk_seg) * SegBytes);
    return 1'b1;
  endfunction

  function automatic void wr_header(logic [6:0] addr, logic [LenW-1:0] len);
    int unsigned tw;
    pk_msg_left   = '0;
    pk_chunk_left = '0;
    if (len == 0) return;
    if (seg_offset() != 0 && !close_seg()) return;
    emit_cmd(CmdStream);
    emit_cmd(CmdStart);
    tw = (len < SegBytes - 5) ? len : SegBytes - 5;
    emit_cmd(CmdOut | 8'(tw + 1));
    emit_cmd({addr, 1'b0});
    pk_msg_left   = len;
    pk_chunk_left = 5'(tw);
  endfunction

  function automatic void wr_data(logic [7:0] b);
    int unsigned tw;
    if (pk_msg_left == 0) begin
      put_res(1'b0, 8'h00, '0, StatUnexpected);
      return;
    end
    // chunk used up: open a follow-on OUT in a fresh segment
    if (pk_chunk_left == 0) begin
      if (seg_offset() != 0 && !close_seg()) return;
      emit_cmd(CmdStream);
      tw = (pk_msg_left < SegBytes - 3) ? pk_msg_left : SegBytes - 3;
      emit_cmd(CmdOut | 8'(tw));
      pk_chunk_left = 5'(tw);
    end
    emit_cmd(b);
    pk_msg_left--;
    pk_chunk_left--;
  endfunction

  function automatic void rd_msg(logic [6:0] addr, logic [LenW-1:0] len);
    bit          started;
    int unsigned left;
    int unsigned pos;
    int unsigned n;
    started = 1'b0;
    left    = len;
    if (len > ReadLenLimit) begin
      put_res(1'b0, 8'h00, '0, StatTooLong);
      return;
    end
    pk_msg_left   = '0;
    pk_chunk_left = '0;
    while (left != 0) begin
      pos = seg_offset();
      // each IN chunk after the first, or a header that won't fit, moves on
      if (pos != 0) begin
        if (started || pos >= SegBytes - 7) begin
          if (!close_seg()) return;
          emit_cmd(CmdStream);
        end
      end else begin
        emit_cmd(CmdStream);
      end
      if (!started) begin
        emit_cmd(CmdStart);
        emit_cmd(CmdOut | 8'd1);
        emit_cmd({addr, 1'b1});
        started = 1'b1;
      end
      n = (left < ReadChunk) ? left : ReadChunk;
      left -= n;
      // the final byte always gets a bare IN of its own
      if (left == 0) begin
        if (n > 1) emit_cmd(CmdIn | 8'(n - 1));
        emit_cmd(CmdIn);
      end else begin
        emit_cmd(CmdIn | 8'(n));
      end
    end
  endfunction

  function automatic void finish_txn();
    cmd_res_t r;
    if (pk_ovf) begin
      put_res(1'b0, 8'h00, '0, StatOverflow);
      clear_packer();
      return;
    end
    // no room for STOP and END together: spill into a new segment
    if (seg_offset() == SegBytes - 1) begin
      if (!close_seg()) begin
        clear_packer();
        return;
      end
      emit_cmd(CmdStream);
    end
    emit_cmd(CmdStop);
    emit_cmd(CmdEnd);
    r = item_cmds.pop_back();
    r.total_length = pk_pos;
    item_cmds.push_back(r);
    clear_packer();
  endfunction

  function automatic void pack_item(stim_row_t it);
    cmd_res_t r;
    item_cmds.delete();
    if (it.op == OP_FINISH) begin
      finish_txn();
    end else if (!pk_ovf) begin
      case (it.op)
        OP_WR_HDR:  wr_header(it.addr, it.len);
        OP_WR_DATA: wr_data(it.data);
        default:    rd_msg(it.addr, it.len);
      endcase
    end
    if (item_cmds.size() > 0) begin
      r = item_cmds.pop_back();
      r.last = 1'b1;
      item_cmds.push_back(r);
    end
  endfunction

  // --------------------------------------------------------------------------
  // stimulus rows
  // --------------------------------------------------------------------------
  function automatic stim_row_t mk_item(op_e op, logic [6:0] addr,
                                        logic [LenW-1:0] len, logic [7:0] data);
    stim_row_t it;
    it      = '0;
    it.op   = op;
    it.addr = addr;
    it.len  = len;
    it.data = data;
    return it;
  endfunction

  function automatic cmd_res_t res(bit has, logic [7:0] b, logic [OffW-1:0] off,
                                   logic [PosW-1:0] total, logic [1:0] st,
                                   bit lst);
    cmd_res_t r;
    r.has_byte     = has;
    r.cmd_byte     = b;
    r.byte_offset  = off;
    r.total_length = total;
    r.status       = st;
    r.last         = lst;
    return r;
  endfunction

  function automatic stim_row_t typed_row(op_e op, logic [6:0] addr,
                                          logic [LenW-1:0] len, logic [7:0] data,
                                          logic [1:0] n, cmd_res_t r0,
                                          cmd_res_t r1);
    stim_row_t it;
    it         = mk_item(op, addr, len, data);
    it.typed   = 1'b1;
    it.n_typed = n;
    it.r0      = r0;
    it.r1      = r1;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // item driver: payload changes at the falling edge, handshake seen at the
  // rising edge; valid stays up while stalled
  // --------------------------------------------------------------------------
  task automatic send_item(input stim_row_t it);
    bit was_ovf;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= it.op;
    dev_addr_i   <= it.addr;
    msg_length_i <= it.len;
    data_byte_i  <= it.data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // accepted at this edge
    was_ovf = pk_ovf;
    pack_item(it);
    if (it.typed) begin
      if (it.n_typed > 0) expected_cmds.push_back(it.r0);
      if (it.n_typed > 1) expected_cmds.push_back(it.r1);
    end else begin
      foreach (item_cmds[k]) expected_cmds.push_back(item_cmds[k]);
    end
    // items dropped after an overflow don't count toward the random part
    if (it.op == OP_FINISH || !was_ovf) items_sent++;
    @(negedge clk_i);
  endtask

  // sender holds off until every awaited result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_cmds.size() != 0);
  endtask

  task automatic random_write(input logic [6:0] addr, input int unsigned len,
                              input int unsigned n_data);
    send_item(mk_item(OP_WR_HDR, addr, LenW'(len), 8'($urandom)));
    repeat (n_data) send_item(mk_item(OP_WR_DATA, 7'($urandom), LenW'($urandom),
                                      8'($urandom)));
    // now and then a byte past the end of the message
    if ($urandom_range(7) == 0)
      send_item(mk_item(OP_WR_DATA, 7'($urandom), LenW'($urandom), 8'($urandom)));
  endtask

  task automatic random_transaction();
    int unsigned n_msgs;
    int unsigned kind;
    int unsigned len;
    int unsigned n_data;
    logic [6:0]  addr;
    bit          big;
    // one in ten runs long enough to use up the segment space
    big    = ($urandom_range(9) == 0);
    n_msgs = big ? 12 : $urandom_range(1, 5);
    repeat (n_msgs) begin
      addr = 7'($urandom);
      kind = $urandom_range(9);
      if (big) begin
        if (kind < 8)
          send_item(mk_item(OP_READ, addr, LenW'($urandom_range(400, ReadLenLimit)),
                            8'($urandom)));
        else
          random_write(addr, 60, 60);
      end else if (kind < 4) begin
        // chunk-boundary lengths are favored, so finish lands on the last slot
        case ($urandom_range(7))
          0:       len = 0;
          1:       len = SegBytes - 5;
          2:       len = SegBytes - 3;
          3:       len = 2 * SegBytes - 8;
          4:       len = $urandom_range(1, 4);
          5:       len = $urandom_range(1, 70);
          6:       len = $urandom_range(71, 4095);
          default: len = 2 * SegBytes - 6;
        endcase
        if (len > 70)                   n_data = $urandom_range(0, 40);
        else if ($urandom_range(4) == 0) n_data = $urandom_range(0, len);
        else                            n_data = len;
        random_write(addr, len, n_data);
      end else if (kind < 8) begin
        case ($urandom_range(7))
          0:       len = 1;
          1:       len = 2;
          2:       len = $urandom_range(ReadChunk - 1, ReadChunk + 1);
          3:       len = ReadLenLimit;
          4:       len = $urandom_range(ReadLenLimit + 1, 4095);
          5:       len = 0;
          default: len = $urandom_range(1, 100);
        endcase
        send_item(mk_item(OP_READ, addr, LenW'(len), 8'($urandom)));
      end else begin
        // stray data byte, usually with no write open
        send_item(mk_item(OP_WR_DATA, addr, LenW'($urandom), 8'($urandom)));
      end
    end
    send_item(mk_item(OP_FINISH, 7'($urandom), LenW'($urandom), 8'($urandom)));
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall, check at the rising edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  function automatic void check_field(string fname, logic [PosW-1:0] want,
                                      logic [PosW-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0d ns: %s mismatch, expected %0h, got %0h", $time, fname,
                 want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0d ns: result with none expected, got has=%0d byte=%0h off=%0d",
                   $time, has_byte_o, cmd_byte_o, byte_offset_o,
                   " total=%0d status=%0d last=%0d", total_length_o, status_o,
                   last_o);
      end else begin
        next_cmd = expected_cmds.pop_front();
        check_field("has_byte", PosW'(next_cmd.has_byte), PosW'(has_byte_o));
        check_field("cmd_byte", PosW'(next_cmd.cmd_byte), PosW'(cmd_byte_o));
        check_field("byte_offset", PosW'(next_cmd.byte_offset), PosW'(byte_offset_o));
        check_field("total_length", next_cmd.total_length, total_length_o);
        check_field("status", PosW'(next_cmd.status), PosW'(status_o));
        check_field("last", PosW'(next_cmd.last), PosW'(last_o));
      end
    end
  end

  // watchdog: cycles without any handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t dir_rows[$];
    int        phase_start;

    // empty transaction: STOP at 0, END at 1, length 2
    dir_rows.push_back(typed_row(OP_FINISH, 7'd0, 12'd0, 8'd0, 2'd2,
                                 res(1'b1, CmdStop, 12'd0, 13'd0, StatOk, 1'b0),
                                 res(1'b1, CmdEnd, 12'd1, 13'd2, StatOk, 1'b1)));
    // data byte with no write open
    dir_rows.push_back(typed_row(OP_WR_DATA, 7'd0, 12'd0, 8'hFF, 2'd1,
                                 res(1'b0, 8'h00, 12'd0, 13'd0, StatUnexpected, 1'b1),
                                 '0));
    // reads just past the limit and at the top of the field
    dir_rows.push_back(typed_row(OP_READ, 7'd127, 12'd513, 8'd0, 2'd1,
                                 res(1'b0, 8'h00, 12'd0, 13'd0, StatTooLong, 1'b1),
                                 '0));
    dir_rows.push_back(typed_row(OP_READ, 7'd0, 12'd4095, 8'd0, 2'd1,
                                 res(1'b0, 8'h00, 12'd0, 13'd0, StatTooLong, 1'b1),
                                 '0));
    // zero-length header: nothing comes out
    dir_rows.push_back(typed_row(OP_WR_HDR, 7'd127, 12'd0, 8'd0, 2'd0, '0, '0));
    // short write at the top address, byte extremes, one byte too many
    dir_rows.push_back(mk_item(OP_WR_HDR, 7'd127, 12'd3, 8'd0));
    dir_rows.push_back(mk_item(OP_WR_DATA, 7'd0, 12'd0, 8'h00));
    dir_rows.push_back(mk_item(OP_WR_DATA, 7'd0, 12'd0, 8'hFF));
    dir_rows.push_back(mk_item(OP_WR_DATA, 7'd0, 12'd0, 8'h5A));
    dir_rows.push_back(typed_row(OP_WR_DATA, 7'd0, 12'd0, 8'h11, 2'd1,
                                 res(1'b0, 8'h00, 12'd0, 13'd0, StatUnexpected, 1'b1),
                                 '0));
    // single-byte read and one just past a full IN chunk
    dir_rows.push_back(mk_item(OP_READ, 7'd0, 12'd1, 8'd0));
    dir_rows.push_back(mk_item(OP_READ, 7'd85, 12'd33, 8'd0));
    // longest write, abandoned by finish
    dir_rows.push_back(mk_item(OP_WR_HDR, 7'd0, 12'd4095, 8'd0));
    dir_rows.push_back(mk_item(OP_WR_DATA, 7'd0, 12'd0, 8'hA5));
    dir_rows.push_back(mk_item(OP_FINISH, 7'd0, 12'd0, 8'd0));
    // full-size reads until the segment space overflows in the ninth
    repeat (9) dir_rows.push_back(mk_item(OP_READ, 7'd42, 12'd512, 8'd0));
    // dropped after overflow, then finish reports it
    dir_rows.push_back(typed_row(OP_WR_HDR, 7'd5, 12'd10, 8'd0, 2'd0, '0, '0));
    dir_rows.push_back(typed_row(OP_WR_DATA, 7'd0, 12'd0, 8'h3C, 2'd0, '0, '0));
    dir_rows.push_back(typed_row(OP_FINISH, 7'd0, 12'd0, 8'd0, 2'd1,
                                 res(1'b0, 8'h00, 12'd0, 13'd0, StatOverflow, 1'b1),
                                 '0));

    // reset held from the start, released at a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) send_item(dir_rows[k]);
    settle();

    // idling phases: none, sender only, receiver only, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 45; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) random_transaction();
      settle();
    end

    stall_pct = 0;
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
